FILE: rtl/fm_index_backward_search_top_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the FM-index backward search block
// Concurrent checks that compile away when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef FM_INDEX_BACKWARD_SEARCH_TOP_ASSERT_SVH
`define FM_INDEX_BACKWARD_SEARCH_TOP_ASSERT_SVH
`ifndef SYNTHESIS
// prop must hold at every clock edge outside reset
`define FMBS_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("fmbs: assertion failed");
// cond must never be true outside reset
`define FMBS_NEVER(lbl, clk, rstn, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
        else $error("fmbs: forbidden condition");
`else
`define FMBS_ASSERT(lbl, clk, rstn, prop)
`define FMBS_NEVER(lbl, clk, rstn, cond)
`endif
`endif

FILE: rtl/fmbs_pkg.sv
// ---------------------------------------------------------------------------
// fmbs_pkg
// Shared types and constants of the FM-index backward search block.
// ---------------------------------------------------------------------------
package fmbs_pkg;

    localparam int MAX_POSITIONS_DEF = 4096;

    localparam int NCLASS = 5;
    localparam int CNT_W  = 13;
    localparam int UPR_W  = 14;

    // register map, index = paddr[3:2]
    localparam logic [1:0] REG_TEXT_LENGTH = 2'd0;
    localparam logic [1:0] REG_MIN_COV     = 2'd1;
    localparam logic [1:0] REG_MAX_COV     = 2'd2;

    localparam logic [CNT_W-1:0] TEXT_LENGTH_RST = 13'd4096;
    localparam logic [CNT_W-1:0] MIN_COV_RST     = 13'd1;
    localparam logic [CNT_W-1:0] MAX_COV_RST     = 13'd4096;

    localparam logic [CNT_W-1:0] SAT13 = 13'h1FFF;
    localparam logic [7:0]       MATCH_SAT = 8'hFF;

    localparam logic ACT_LOAD   = 1'b0;
    localparam logic ACT_SEARCH = 1'b1;

    localparam logic [2:0] CLS_END   = 3'd0;
    localparam logic [2:0] NUM_CLASS = 3'd5;
    localparam logic [2:0] COMP_BASE = 3'd5;

    // front-to-back queue
    localparam int QDEPTH = 2;
    localparam int QPW    = $clog2(QDEPTH);
    localparam int QCW    = $clog2(QDEPTH + 1);

    // one occurrence row, [0] = sentinel ... [4] = t
    typedef logic [NCLASS-1:0][CNT_W-1:0] t_row;

    typedef struct packed {
        logic [CNT_W-1:0] text_length;
        logic [CNT_W-1:0] min_cov;
        logic [CNT_W-1:0] max_cov;
    } t_cfg;

    // classified word handed from front to back
    typedef struct packed {
        logic             is_load;
        logic [CNT_W-1:0] row;
        t_row             counts;
        logic [2:0]       cls;      // after complement
        logic             sym_ok;   // class within alphabet
        logic             restart;
    } t_item;

    typedef struct packed {
        logic                    in_cov;
        logic                    found;
        logic [7:0]              matched;
        logic [CNT_W-1:0]        size;
        logic signed [UPR_W-1:0] upper;
        logic [CNT_W-1:0]        lower;
    } t_result;

endpackage

FILE: rtl/fmbs_ram.sv
// ---------------------------------------------------------------------------
// fmbs_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ---------------------------------------------------------------------------
module fmbs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/fmbs_front.sv
// ---------------------------------------------------------------------------
// fmbs_front
// Accepts input words, resolves the symbol class and queues them.
// ---------------------------------------------------------------------------
`include "fm_index_backward_search_top_assert.svh"

module fmbs_front
    import fmbs_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic             i_action,
    input  logic [CNT_W-1:0] i_row,
    input  t_row             i_counts,
    input  logic [2:0]       i_sym,
    input  logic             i_restart,
    input  logic             i_comp,
    output t_item            o_item,
    output logic             o_item_valid,
    input  logic             i_pop
);

    t_item            n_item;
    t_item            r_q [QDEPTH];
    logic [QPW-1:0]   r_wr_ptr;
    logic [QPW-1:0]   r_rd_ptr;
    logic [QCW-1:0]   r_count;
    logic             push;
    logic             pop;

    always_comb begin
        n_item.is_load = (i_action == ACT_LOAD);
        n_item.row     = i_row;
        n_item.counts  = i_counts;
        n_item.sym_ok  = (i_sym < NUM_CLASS);
        n_item.restart = i_restart;
        // complement swaps a<->t and c<->g; sentinel stays
        if (i_comp && i_sym != CLS_END && n_item.sym_ok) begin
            n_item.cls = COMP_BASE - i_sym;
        end else begin
            n_item.cls = i_sym;
        end
    end

    assign o_ready      = (r_count != QCW'(QDEPTH));
    assign push         = i_valid && o_ready;
    assign o_item_valid = (r_count != '0);
    assign pop          = i_pop && o_item_valid;
    assign o_item       = r_q[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr_ptr] <= n_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == QPW'(QDEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == QPW'(QDEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({push, pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    `FMBS_NEVER(a_q_overflow, i_clk, i_rst_n, r_count > QCW'(QDEPTH))

endmodule

FILE: rtl/fmbs_back.sv
// ---------------------------------------------------------------------------
// fmbs_back
// Executes queued words: table loads, interval restart and one-symbol
// extension, then forms the result word.
// ---------------------------------------------------------------------------
`include "fm_index_backward_search_top_assert.svh"

module fmbs_back
    import fmbs_pkg::*;
#(
    parameter int MAX_POSITIONS = MAX_POSITIONS_DEF
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_cfg    i_cfg,
    input  t_item   i_item,
    input  logic    i_item_valid,
    output logic    o_pop,
    output t_result o_res,
    output logic    o_res_valid,
    input  logic    i_res_ready
);

    localparam int DEPTH = MAX_POSITIONS + 1;
    localparam int AW    = $clog2(DEPTH);
    localparam int XW    = (AW > UPR_W) ? AW : UPR_W;
    localparam int RW    = NCLASS * CNT_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_WAIT,
        S_CALC
    } t_state;

    t_state                  r_state;
    logic [CNT_W-1:0]        r_lower;
    logic signed [UPR_W-1:0] r_upper;
    logic [7:0]              r_match;
    logic [CNT_W-1:0]        r_start [NCLASS];
    logic [2:0]              r_cls;
    logic                    r_lo_ok;
    logic                    r_hi_ok;
    t_result                 r_out;
    logic                    r_out_valid;

    // IDLE-cycle decode
    logic [CNT_W-1:0]        eff_lower;
    logic signed [UPR_W-1:0] eff_upper;
    logic [7:0]              eff_match;
    logic                    eff_found;
    logic                    step;
    logic [UPR_W-1:0]        hi_row;
    logic [XW-1:0]           lo_ext;
    logic [XW-1:0]           hi_ext;
    logic [XW-1:0]           wr_ext;
    logic                    wr_ok;
    logic                    ram_we;
    logic                    cap_start;
    logic [CNT_W-1:0]        n_start [NCLASS];
    logic                    restart_pop;

    // WAIT-cycle extension
    t_row                    rd_lo;
    t_row                    rd_hi;
    logic [CNT_W-1:0]        occ_l;
    logic [CNT_W-1:0]        occ_u;
    logic [CNT_W-1:0]        st;
    logic [UPR_W-1:0]        nl;
    logic signed [UPR_W:0]   nu;
    logic [CNT_W-1:0]        n_lower;
    logic signed [UPR_W-1:0] n_upper;

    // CALC-cycle result
    logic                    found;
    logic signed [UPR_W:0]   diff;
    logic [UPR_W-1:0]        size14;
    t_result                 n_out;
    logic                    out_free;

    assign o_pop       = (r_state == S_IDLE) && i_item_valid;
    assign restart_pop = o_pop && i_item.restart && !i_item.is_load;

    always_comb begin
        if (i_item.restart && !i_item.is_load) begin
            eff_lower = '0;
            eff_upper = $signed({1'b0, i_cfg.text_length}) - 14'sd1;
            eff_match = '0;
        end else begin
            eff_lower = r_lower;
            eff_upper = r_upper;
            eff_match = r_match;
        end
        eff_found = $signed({1'b0, eff_lower}) <= eff_upper;
        step      = !i_item.is_load && i_item.sym_ok && eff_found;
        hi_row    = $unsigned(eff_upper + 14'sd1);
        lo_ext    = XW'({1'b0, eff_lower});
        hi_ext    = XW'(hi_row);
        wr_ext    = XW'(i_item.row);
        wr_ok     = (wr_ext <= XW'(MAX_POSITIONS));
        ram_we    = o_pop && i_item.is_load && wr_ok;
        cap_start = ram_we && (i_item.row == i_cfg.text_length);
        // class starts are running sums of the totals row
        n_start[0] = '0;
        for (int k = 1; k < NCLASS; k++) begin
            n_start[k] = n_start[k-1] + i_item.counts[k-1];
        end
    end

    // two copies of the table so both bounds are read in the same cycle
    fmbs_ram #(.WIDTH(RW), .DEPTH(DEPTH)) u_ram_lo (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (wr_ext[AW-1:0]),
        .i_wdata (i_item.counts),
        .i_raddr (lo_ext[AW-1:0]),
        .o_rdata (rd_lo)
    );

    fmbs_ram #(.WIDTH(RW), .DEPTH(DEPTH)) u_ram_hi (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (wr_ext[AW-1:0]),
        .i_wdata (i_item.counts),
        .i_raddr (hi_ext[AW-1:0]),
        .o_rdata (rd_hi)
    );

    always_comb begin
        occ_l = r_lo_ok ? rd_lo[r_cls] : '0;
        occ_u = r_hi_ok ? rd_hi[r_cls] : '0;
        st    = r_start[r_cls];
        nl    = {1'b0, st} + {1'b0, occ_l};
        nu    = $signed({2'b0, st}) + $signed({2'b0, occ_u}) - 15'sd1;
        n_lower = (nl > UPR_W'(SAT13)) ? SAT13 : nl[CNT_W-1:0];
        if (nu > $signed({2'b0, SAT13})) begin
            n_upper = $signed({1'b0, SAT13});
        end else begin
            n_upper = nu[UPR_W-1:0];
        end
    end

    always_comb begin
        found  = $signed({1'b0, r_lower}) <= r_upper;
        diff   = $signed({r_upper[UPR_W-1], r_upper}) - $signed({2'b0, r_lower}) + 15'sd1;
        size14 = found ? diff[UPR_W-1:0] : '0;
        n_out.lower   = r_lower;
        n_out.upper   = r_upper;
        n_out.size    = (size14 > UPR_W'(SAT13)) ? SAT13 : size14[CNT_W-1:0];
        n_out.matched = r_match;
        n_out.found   = found;
        n_out.in_cov  = (size14 >= {1'b0, i_cfg.min_cov}) &&
                        (size14 <= {1'b0, i_cfg.max_cov});
        out_free = !r_out_valid || i_res_ready;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_lower     <= '0;
            r_upper     <= $signed({1'b0, TEXT_LENGTH_RST}) - 14'sd1;
            r_match     <= '0;
            r_out_valid <= 1'b0;
            for (int k = 0; k < NCLASS; k++) begin
                r_start[k] <= '0;
            end
        end else begin
            if (r_state == S_CALC && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_res_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (o_pop) begin
                        r_lower <= eff_lower;
                        r_upper <= eff_upper;
                        r_match <= eff_match;
                        r_cls   <= i_item.cls;
                        r_lo_ok <= (lo_ext <= XW'(MAX_POSITIONS));
                        r_hi_ok <= (hi_ext <= XW'(MAX_POSITIONS));
                        if (cap_start) begin
                            for (int k = 0; k < NCLASS; k++) begin
                                r_start[k] <= n_start[k];
                            end
                        end
                        r_state <= step ? S_WAIT : S_CALC;
                    end
                end
                S_WAIT: begin
                    r_lower <= n_lower;
                    r_upper <= n_upper;
                    if (r_match != MATCH_SAT) begin
                        r_match <= r_match + 8'd1;
                    end
                    r_state <= S_CALC;
                end
                S_CALC: begin
                    if (out_free) begin
                        r_out   <= n_out;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_res       = r_out;
    assign o_res_valid = r_out_valid;

    `FMBS_ASSERT(a_wait_to_calc, i_clk, i_rst_n, (r_state == S_WAIT) |=> (r_state == S_CALC))
    `FMBS_ASSERT(a_calc_hold, i_clk, i_rst_n, (r_state == S_CALC && !out_free) |=> (r_state == S_CALC))
    `FMBS_ASSERT(a_found_size, i_clk, i_rst_n, r_out_valid |-> (r_out.found == (r_out.size != '0)))
    `FMBS_ASSERT(a_restart_len, i_clk, i_rst_n, restart_pop |=> (r_match <= 8'd1))

endmodule

FILE: rtl/fm_index_backward_search_top.sv
// Back end: a search word passes pop with table read (IDLE), bound update
// (WAIT) and result register (CALC); loads and non-extending steps skip WAIT.
// A word is popped only after the last result is registered (CALC may stall),
// as the table read is registered and each step uses the previous interval.
// Reset (i_rst_n low, synchronous): queue and result register empty, interval
// [0, 4095], length 0, class starts zero; table contents stay undefined.
// ---------------------------------------------------------------------------
// fm_index_backward_search_top
// FM-index backward search with an APB register port and stream channels.
// ---------------------------------------------------------------------------
module fm_index_backward_search_top
    import fmbs_pkg::*;
#(
    parameter int MAX_POSITIONS = MAX_POSITIONS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [12:0] row_index, [25:13] count_end, [38:26] count_a, [51:39] count_c,
    // [64:52] count_g, [77:65] count_t, [80:78] symbol_class, [81] restart,
    // [82] complement, [87:83] zero
    input  logic [87:0] s_axis_tdata,
    // [0] action (0 load row, 1 search step)
    input  logic [0:0]  s_axis_tuser,
    // output stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [12:0] interval_lower, [26:13] interval_upper, [39:27] interval_size,
    // [47:40] matched_length, [48] found, [49] in_coverage, [55:50] zero
    output logic [55:0] m_axis_tdata,
    // register port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    t_cfg    r_cfg;
    logic    cfg_wr;
    t_item   q_item;
    logic    q_valid;
    logic    q_pop;
    t_result res;
    t_row    in_counts;

    // ---------------- register port ----------------
    // zero-wait-state APB; registers decoded on paddr[3:2]
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.text_length <= TEXT_LENGTH_RST;
            r_cfg.min_cov     <= MIN_COV_RST;
            r_cfg.max_cov     <= MAX_COV_RST;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                REG_TEXT_LENGTH: r_cfg.text_length <= pwdata[CNT_W-1:0];
                REG_MIN_COV:     r_cfg.min_cov     <= pwdata[CNT_W-1:0];
                REG_MAX_COV:     r_cfg.max_cov     <= pwdata[CNT_W-1:0];
                default:         r_cfg             <= r_cfg;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_TEXT_LENGTH: prdata = {19'd0, r_cfg.text_length};
            REG_MIN_COV:     prdata = {19'd0, r_cfg.min_cov};
            REG_MAX_COV:     prdata = {19'd0, r_cfg.max_cov};
            default:         prdata = '0;
        endcase
    end

    // ---------------- front: accept, classify, queue ----------------
    assign in_counts = s_axis_tdata[77:13];

    fmbs_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (s_axis_tvalid),
        .o_ready      (s_axis_tready),
        .i_action     (s_axis_tuser[0]),
        .i_row        (s_axis_tdata[12:0]),
        .i_counts     (in_counts),
        .i_sym        (s_axis_tdata[80:78]),
        .i_restart    (s_axis_tdata[81]),
        .i_comp       (s_axis_tdata[82]),
        .o_item       (q_item),
        .o_item_valid (q_valid),
        .i_pop        (q_pop)
    );

    // ---------------- back: table, interval update, result ----------------
    fmbs_back #(.MAX_POSITIONS(MAX_POSITIONS)) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_item       (q_item),
        .i_item_valid (q_valid),
        .o_pop        (q_pop),
        .o_res        (res),
        .o_res_valid  (m_axis_tvalid),
        .i_res_ready  (m_axis_tready)
    );

    assign m_axis_tdata = {6'd0, res.in_cov, res.found, res.matched, res.size,
                           $unsigned(res.upper), res.lower};

endmodule

FILE: test/testbench.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// FM-index backward search testbench
// Drives load and search words into fm_index_backward_search_top over the
// input stream, sets its registers over APB, and checks every result word
// against an in-bench model of the occurrence table and suffix interval.
// ---------------------------------------------------------------------------
module testbench;
    import fmbs_pkg::*;

    localparam int RX_IDLE_PCT    = 38;
    localparam int TX_IDLE_PCT    = 38;
    localparam int RANDOM_WORDS   = 1800;
    localparam int RX_HOLD_CYCLES = 300;
    localparam int DRAIN_SETTLE   = 8;
    // worst case: receiver hold plus back-end latency, then several times over
    localparam int STALL_LIMIT    = 5000;

    typedef enum logic [2:0] {
        SYM_END  = 3'd0,
        SYM_A    = 3'd1,
        SYM_C    = 3'd2,
        SYM_G    = 3'd3,
        SYM_T    = 3'd4,
        SYM_OUT5 = 3'd5,
        SYM_OUT7 = 3'd7
    } t_base;

    // one input word; tuser carries action, the rest packs into tdata
    typedef struct packed {
        logic             action;
        logic             complement;
        logic             restart;
        logic [2:0]       sym;
        t_row             counts;
        logic [CNT_W-1:0] row;
    } t_fm_word;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    // [12:0] row_index, [25:13] count_end, [38:26] count_a, [51:39] count_c,
    // [64:52] count_g, [77:65] count_t, [80:78] symbol_class, [81] restart,
    // [82] complement, [87:83] zero
    logic [87:0] s_axis_tdata;
    // [0] action
    logic [0:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    // [12:0] interval_lower, [26:13] interval_upper, [39:27] interval_size,
    // [47:40] matched_length, [48] found, [49] in_coverage, [55:50] zero
    logic [55:0] m_axis_tdata;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    fm_index_backward_search_top i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // ---- interval model ----------------------------------------------------
    logic [CNT_W-1:0] occ_rows [0:MAX_POSITIONS_DEF][NCLASS];
    logic [CNT_W-1:0] class_base [NCLASS] = '{default: '0};
    logic [CNT_W-1:0] sa_lower  = '0;
    int               sa_upper  = int'(TEXT_LENGTH_RST) - 1;
    int               match_len = 0;
    logic [CNT_W-1:0] cfg_text_len = TEXT_LENGTH_RST;
    logic [CNT_W-1:0] cfg_min_cov  = MIN_COV_RST;
    logic [CNT_W-1:0] cfg_max_cov  = MAX_COV_RST;

    t_result pending_intervals [$];
    int      mismatch_count = 0;
    int      words_sent     = 0;
    int      rx_hold        = 0;
    bit      tx_calm        = 1'b0;
    bit      rx_calm        = 1'b0;

    // rows past the table read as zero
    function automatic int occ_at(input int row, input int cls);
        if (row > MAX_POSITIONS_DEF)
            return 0;
        return int'(occ_rows[row][cls]);
    endfunction

    function automatic t_result advance_interval(input t_fm_word w);
        t_result r;
        int      c;
        int      nl;
        int      nu;
        int      size;
        bit      hit;
        if (w.action == ACT_LOAD) begin
            if (w.row <= MAX_POSITIONS_DEF) begin
                for (int k = 0; k < NCLASS; k++)
                    occ_rows[w.row][k] = w.counts[k];
                // totals row: class starts are prefix sums, wrapping at 13 bits
                if (w.row == cfg_text_len) begin
                    class_base[0] = '0;
                    for (int k = 1; k < NCLASS; k++)
                        class_base[k] = class_base[k-1] + occ_rows[w.row][k-1];
                end
            end
        end else begin
            if (w.restart) begin
                sa_lower  = '0;
                sa_upper  = int'(cfg_text_len) - 1;
                match_len = 0;
            end
            // empty interval or out-of-alphabet symbol holds everything
            if (int'(sa_lower) <= sa_upper && w.sym < NUM_CLASS) begin
                c = int'(w.sym);
                if (w.complement && c != int'(CLS_END))
                    c = int'(COMP_BASE) - c;
                nl = int'(class_base[c]) + occ_at(int'(sa_lower), c);
                nu = int'(class_base[c]) + occ_at(sa_upper + 1, c) - 1;
                sa_lower = (nl > int'(SAT13)) ? SAT13 : nl[CNT_W-1:0];
                sa_upper = (nu > int'(SAT13)) ? int'(SAT13) : nu;
                if (match_len < int'(MATCH_SAT))
                    match_len++;
            end
        end
        hit  = int'(sa_lower) <= sa_upper;
        size = hit ? sa_upper - int'(sa_lower) + 1 : 0;
        r.lower   = sa_lower;
        r.upper   = sa_upper[UPR_W-1:0];
        r.size    = (size > int'(SAT13)) ? SAT13 : size[CNT_W-1:0];
        r.matched = match_len[7:0];
        r.found   = hit;
        r.in_cov  = (size >= int'(cfg_min_cov)) && (size <= int'(cfg_max_cov));
        return r;
    endfunction

    // ---- word builders -----------------------------------------------------
    function automatic logic [CNT_W-1:0] rand_count();
        case ($urandom_range(3))
            0: return '0;
            1: return 13'd4096;
            default: return CNT_W'($urandom_range(4096));
        endcase
    endfunction

    function automatic t_row rand_row();
        t_row r;
        for (int k = 0; k < NCLASS; k++)
            r[k] = rand_count();
        return r;
    endfunction

    function automatic t_fm_word load_word(input int row, input t_row counts);
        t_fm_word w;
        w.action     = ACT_LOAD;
        w.row        = row[CNT_W-1:0];
        w.counts     = counts;
        // don't-care fields carry noise
        w.sym        = 3'($urandom_range(7));
        w.restart    = 1'($urandom_range(1));
        w.complement = 1'($urandom_range(1));
        return w;
    endfunction

    function automatic t_fm_word search_word(input logic [2:0] sym, input bit restart,
                                             input bit comp);
        t_fm_word w;
        w.action     = ACT_SEARCH;
        w.row        = CNT_W'($urandom_range(8191));
        w.counts     = rand_row();
        w.sym        = sym;
        w.restart    = restart;
        w.complement = comp;
        return w;
    endfunction

    function automatic logic [2:0] pick_base();
        if ($urandom_range(9) == 0)
            return SYM_END;
        return 3'($urandom_range(SYM_T, SYM_A));
    endfunction

    function automatic t_fm_word noise_word();
        case ($urandom_range(9))
            0, 1: return load_word($urandom_range(MAX_POSITIONS_DEF), rand_row());
            2: return load_word(int'(cfg_text_len), rand_row());
            3: return load_word($urandom_range(8191, MAX_POSITIONS_DEF + 1), rand_row());
            default: return search_word(3'($urandom_range(7)), 1'($urandom_range(1)),
                                        1'($urandom_range(1)));
        endcase
    endfunction

    function void check_field(input string name, input int exp, input int act);
        if (exp != act) begin
            $error("%s: expected %0d, got %0d", name, exp, act);
            mismatch_count++;
        end
    endfunction

    // ---- clock -------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // ---- sender: entered and left just after a falling edge ----------------
    task automatic send_word(input t_fm_word w);
        if (!tx_calm)
            while ($urandom_range(99) < TX_IDLE_PCT)
                @(negedge i_clk);
        s_axis_tuser  = w.action;
        s_axis_tdata  = {5'd0, w.complement, w.restart, w.sym, w.counts, w.row};
        s_axis_tvalid = 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        pending_intervals = {pending_intervals, advance_interval(w)};
        words_sent++;
        @(negedge i_clk);
        // a following send_word in this step raises it again
        s_axis_tvalid = 1'b0;
    endtask

    task automatic wait_drain();
        while (pending_intervals.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_SETTLE) @(negedge i_clk);
    endtask

    // APB write then read-back; only called with the block idle
    task automatic set_reg(input logic [1:0] idx, input logic [CNT_W-1:0] value);
        wait_drain();
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = {19'd0, value};
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        case (idx)
            REG_TEXT_LENGTH: cfg_text_len = value;
            REG_MIN_COV:     cfg_min_cov  = value;
            REG_MAX_COV:     cfg_max_cov  = value;
            default: ;
        endcase
        @(negedge i_clk);
        penable = 1'b0;
        pwrite  = 1'b0;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        check_field("prdata", int'({19'd0, value}), int'(prdata));
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    // rows 0..n of a random text; all_a gives an identity map for base a
    task automatic load_table(input int n, input bit all_a);
        t_row cnt;
        int   sent_pos;
        int   s;
        cnt      = '0;
        sent_pos = (n > 0) ? $urandom_range(n - 1) : 0;
        for (int r = 0; r <= n; r++) begin
            send_word(load_word(r, cnt));
            if (r < n) begin
                if (all_a)
                    s = SYM_A;
                else if (r == sent_pos)
                    s = SYM_END;
                else
                    s = $urandom_range(SYM_T, SYM_A);
                cnt[s] = cnt[s] + 1'b1;
            end
        end
    endtask

    task automatic run_query(input int len);
        bit comp;
        comp = ($urandom_range(3) == 0);
        send_word(search_word(pick_base(), 1'b1, comp));
        repeat (len - 1) send_word(search_word(pick_base(), 1'b0, comp));
    endtask

    // ---- tests -------------------------------------------------------------
    // whole table written once so no search ever reads an unset row;
    // the first word also reports the reset interval
    task automatic test_table_fill();
        load_table(MAX_POSITIONS_DEF, 1'b0);
    endtask

    task automatic test_directed_cases();
        t_row full;
        set_reg(REG_TEXT_LENGTH, 13'd8);
        set_reg(REG_MIN_COV, 13'd1);
        set_reg(REG_MAX_COV, 13'd8);
        load_table(8, 1'b0);
        send_word(search_word(SYM_A, 1'b1, 1'b0));
        send_word(search_word(SYM_C, 1'b0, 1'b0));
        send_word(search_word(SYM_G, 1'b0, 1'b1));     // complement -> c
        send_word(search_word(SYM_T, 1'b0, 1'b1));     // complement -> a
        send_word(search_word(SYM_END, 1'b1, 1'b1));   // sentinel stays put
        send_word(search_word(SYM_OUT5, 1'b0, 1'b0));  // ignored
        send_word(search_word(SYM_OUT7, 1'b1, 1'b0));  // restart, step ignored
        send_word(search_word(SYM_END, 1'b0, 1'b0));
        send_word(search_word(SYM_END, 1'b0, 1'b0));
        send_word(search_word(SYM_A, 1'b0, 1'b0));
        // loads past the table are dropped
        for (int k = 0; k < NCLASS; k++)
            full[k] = 13'd4096;
        send_word(load_word(8191, full));
        send_word(load_word(MAX_POSITIONS_DEF + 1, full));
        // totals row that pushes class starts to the top: bounds saturate
        set_reg(REG_TEXT_LENGTH, 13'd4096);
        full[0] = 13'd4095;
        send_word(load_word(MAX_POSITIONS_DEF, full));
        send_word(search_word(SYM_C, 1'b1, 1'b0));
        send_word(search_word(SYM_C, 1'b0, 1'b0));     // reads past table
        send_word(search_word(SYM_T, 1'b1, 1'b0));
        // zero-length text: restart gives [0,-1], coverage from min of zero
        set_reg(REG_TEXT_LENGTH, 13'd0);
        set_reg(REG_MIN_COV, 13'd0);
        send_word(search_word(SYM_A, 1'b1, 1'b0));
        send_word(search_word(SYM_G, 1'b0, 1'b0));
        send_word(load_word(0, rand_row()));
    endtask

    // identity table for a: length counter runs into saturation
    task automatic test_long_match();
        set_reg(REG_TEXT_LENGTH, 13'd5);
        set_reg(REG_MIN_COV, 13'd0);
        set_reg(REG_MAX_COV, 13'd4096);
        load_table(5, 1'b1);
        tx_calm = 1'b1;
        rx_calm = 1'b1;
        send_word(search_word(SYM_A, 1'b1, 1'b0));
        repeat (299) begin
            if ($urandom_range(1))
                send_word(search_word(SYM_A, 1'b0, 1'b0));
            else
                send_word(search_word(SYM_T, 1'b0, 1'b1));
        end
        tx_calm = 1'b0;
        rx_calm = 1'b0;
    endtask

    // receiver holds off while the sender keeps offering; then a full drain
    task automatic test_backpressure();
        set_reg(REG_TEXT_LENGTH, 13'd24);
        load_table(24, 1'b0);
        rx_hold = RX_HOLD_CYCLES;
        repeat (8) run_query($urandom_range(8, 2));
        wait_drain();
        repeat (4) run_query($urandom_range(8, 2));
    endtask

    task automatic test_random_phases();
        int first;
        int n;
        int pick;
        first = words_sent;
        while (words_sent - first < RANDOM_WORDS) begin
            pick = $urandom_range(99);
            if (pick < 5)
                n = 1;
            else if (pick < 70)
                n = $urandom_range(40, 2);
            else if (pick < 90)
                n = $urandom_range(300, 41);
            else if (pick < 95)
                n = 0;
            else
                n = MAX_POSITIONS_DEF;
            set_reg(REG_TEXT_LENGTH, n[CNT_W-1:0]);
            case ($urandom_range(3))
                0: set_reg(REG_MIN_COV, 13'd0);
                1: set_reg(REG_MIN_COV, 13'd4096);
                default: set_reg(REG_MIN_COV, CNT_W'($urandom_range(n)));
            endcase
            case ($urandom_range(3))
                0: set_reg(REG_MAX_COV, 13'd0);
                1: set_reg(REG_MAX_COV, 13'd4096);
                default: set_reg(REG_MAX_COV, CNT_W'($urandom_range(n)));
            endcase
            // the full-size case reuses whatever the table holds
            if (n >= 1 && n <= 300)
                load_table(n, $urandom_range(9) == 0);
            tx_calm = ($urandom_range(4) == 0);
            rx_calm = ($urandom_range(4) == 0);
            repeat (12) begin
                if ($urandom_range(4) != 0)
                    run_query($urandom_range(12, 1));
                else
                    repeat ($urandom_range(4, 1)) send_word(noise_word());
            end
        end
        tx_calm = 1'b0;
        rx_calm = 1'b0;
    endtask

    // ---- receiver ready ----------------------------------------------------
    initial begin
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (rx_hold > 0) begin
                rx_hold--;
                m_axis_tready = 1'b0;
            end else begin
                m_axis_tready = rx_calm || ($urandom_range(99) >= RX_IDLE_PCT);
            end
        end
    end

    // ---- result checker ----------------------------------------------------
    initial begin
        t_result got;
        t_result want;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
                got = t_result'(m_axis_tdata[49:0]);
                if (pending_intervals.size() == 0) begin
                    $error("result word with no pending interval");
                    mismatch_count++;
                end else begin
                    want = pending_intervals.pop_front();
                    check_field("interval_lower", int'(want.lower), int'(got.lower));
                    check_field("interval_upper", int'(want.upper), int'(got.upper));
                    check_field("interval_size", int'(want.size), int'(got.size));
                    check_field("matched_length", int'(want.matched), int'(got.matched));
                    check_field("found", int'(want.found), int'(got.found));
                    check_field("in_coverage", int'(want.in_cov), int'(got.in_cov));
                end
            end
        end
    end

    // ---- watchdog: cycles with no word moving on either stream -------------
    initial begin
        int stall_cycles;
        stall_cycles = 0;
        while (stall_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                stall_cycles = 0;
            else
                stall_cycles++;
        end
        $display("Mismatches found");
        $finish;
    end

    // ---- main sequence -----------------------------------------------------
    initial begin
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_table_fill();
        test_directed_cases();
        test_long_match();
        test_backpressure();
        test_random_phases();

        wait_drain();
        repeat (10) @(posedge i_clk);
        if (mismatch_count == 0 && pending_intervals.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
